>>> src/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned SIZE_W = 21;
   localparam int unsigned OFFS_W = 20;
   localparam logic [SIZE_W-1:0] HEAP_LIMIT = 21'd1048576;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_RESIZE  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NULL    = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_HEAP_BASE  = 1'd0,
      CSR_HEAP_BYTES = 1'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT,
      S_DECODE,
      S_FIND_RD,
      S_FIND_CHK,
      S_FIT_RD,
      S_FIT_CHK,
      S_SPLIT_RD,
      S_SPLIT_WR,
      S_SPLIT_SET,
      S_FREE_MARK,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_DEL_RD,
      S_DEL_WR,
      S_SUM_RD,
      S_SUM_ACC,
      S_RESP
   } state_type;

   // one table entry
   typedef struct packed {
      logic [OFFS_W-1:0] offset;
      logic [SIZE_W-1:0] size;
      logic              is_free;
   } entry_type;
endpackage
`default_nettype wire

>>> src/ffha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [20:0] request_size;
   logic [31:0] address;
   modport source (output valid, req_type, request_size, address, input ready);
   modport sink (input valid, req_type, request_size, address, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] address_out;
   logic [20:0] copy_bytes;
   logic [20:0] bytes_used;
   logic [20:0] bytes_free;
   modport source (output valid, status, address_out, copy_bytes, bytes_used, bytes_free,
                   input ready);
   modport sink (input valid, status, address_out, copy_bytes, bytes_used, bytes_free,
                 output ready);
endinterface

interface ffha_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// a table scan reads each entry in a read state, then tests it in a check state
// longest item is a moving resize: find, fit, shift, find again, merge, sum
// one item at a time; a finished response waits in its own register while the next word runs
// reset (synchronous) and any csr write rebuild the table as one free block in the S_INIT state
module first_fit_heap_allocator_top #(
   parameter int unsigned MAX_BLOCKS = 64,
   parameter int unsigned HEADER_BYTES = 12,
   parameter int unsigned MIN_SPLIT_BYTES = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   ffha_req_if.sink   req,
   ffha_rsp_if.source rsp,
   ffha_csr_if.sink   csr
);
   import ffha_pkg::*;
   ffha_seq #(
      .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES),
      .MIN_SPLIT_BYTES(MIN_SPLIT_BYTES)
   ) u_seq (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );
endmodule
`default_nettype wire

>>> src/ffha_table.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_table #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW = 6
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire ffha_pkg::entry_type  wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output ffha_pkg::entry_type       rd_data
);
   import ffha_pkg::*;
   entry_type mem [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule
`default_nettype wire

>>> src/ffha_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_seq #(
   parameter int unsigned MAX_BLOCKS = 64,
   parameter int unsigned HEADER_BYTES = 12,
   parameter int unsigned MIN_SPLIT_BYTES = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ffha_req_if.sink  req,
   ffha_rsp_if.source rsp,
   ffha_csr_if.sink  csr
);
   import ffha_pkg::*;
   localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
   localparam logic [SIZE_W+1:0] SPLIT_EXTRA = (SIZE_W+2)'(HEADER_BYTES + MIN_SPLIT_BYTES);

   state_type state_ff, state_in;
   logic [31:0] base_ff, base_in;
   logic [SIZE_W-1:0] hbytes_ff, hbytes_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;      // scan / shift pointer
   logic [CW-1:0] hit_ff, hit_in;      // entry found or fitted
   logic [1:0] kind_ff, kind_in;
   logic [SIZE_W-1:0] rsize_ff, rsize_in;
   logic [SIZE_W:0] need_ff, need_in;  // rounded size can reach 2^21
   logic [31:0] addr_ff, addr_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] aout_ff, aout_in;
   logic [SIZE_W-1:0] copy_ff, copy_in;
   logic [SIZE_W-1:0] used_ff, used_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [SIZE_W-1:0] old_ff, old_in;
   logic moving_ff, moving_in;         // resize: free old block after alloc
   logic [2:0] find_ret_ff, find_ret_in;
   entry_type held_ff, held_in;        // fitted entry during split/shift, entry i during merge
   logic rvalid_ff, rvalid_in;
   // output word, held while the next item runs
   logic [1:0] out_status_ff, out_status_in;
   logic [31:0] out_aout_ff, out_aout_in;
   logic [SIZE_W-1:0] out_copy_ff, out_copy_in;
   logic [SIZE_W-1:0] out_used_ff, out_used_in;
   logic [SIZE_W-1:0] out_free_ff, out_free_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic [31:0] paddr;

   localparam logic [2:0] RET_REL = 3'd0, RET_RSZ = 3'd1, RET_MOVE = 3'd2;

   ffha_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign paddr = base_ff + 32'(rd_data.offset) + 32'(HEADER_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         base_ff <= '0;
         hbytes_ff <= HEAP_LIMIT;
         count_ff <= CW'(1);
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         hbytes_ff <= hbytes_in;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
      end
      idx_ff <= idx_in; hit_ff <= hit_in; kind_ff <= kind_in; rsize_ff <= rsize_in;
      need_ff <= need_in; addr_ff <= addr_in; status_ff <= status_in;
      aout_ff <= aout_in; copy_ff <= copy_in; used_ff <= used_in; free_ff <= free_in;
      old_ff <= old_in; moving_ff <= moving_in; find_ret_ff <= find_ret_in;
      held_ff <= held_in;
      out_status_ff <= out_status_in; out_aout_ff <= out_aout_in;
      out_copy_ff <= out_copy_in; out_used_ff <= out_used_in; out_free_ff <= out_free_in;
   end

   always_comb begin
      logic [SIZE_W+1:0] big;
      logic [SIZE_W-1:0] hb;
      state_in = state_ff; base_in = base_ff; hbytes_in = hbytes_ff;
      count_in = count_ff; idx_in = idx_ff; hit_in = hit_ff; kind_in = kind_ff;
      rsize_in = rsize_ff; need_in = need_ff; addr_in = addr_ff;
      status_in = status_ff; aout_in = aout_ff; copy_in = copy_ff;
      used_in = used_ff; free_in = free_ff; old_in = old_ff; moving_in = moving_ff;
      find_ret_in = find_ret_ff; held_in = held_ff; rvalid_in = rvalid_ff;
      out_status_in = out_status_ff; out_aout_in = out_aout_ff;
      out_copy_in = out_copy_ff; out_used_in = out_used_ff; out_free_in = out_free_ff;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data; rd_addr = idx_ff[AW-1:0];
      big = '0;
      hb = (hbytes_ff > HEAP_LIMIT) ? HEAP_LIMIT : hbytes_ff;
      req.ready = 1'b0;
      csr.ready = (state_ff == S_IDLE) && !rvalid_ff;
      if (rvalid_ff && rsp.ready) begin
         rvalid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            req.ready = !(csr.valid && csr.ready);
            if (csr.valid && csr.ready) begin
               if (csr.index == CSR_HEAP_BASE) base_in = csr.data;
               else hbytes_in = csr.data[SIZE_W-1:0];
               state_in = S_INIT;
            end else if (req.valid && req.ready) begin
               kind_in = req.req_type; rsize_in = req.request_size;
               addr_in = req.address;
               need_in = ({1'b0, req.request_size} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
               status_in = ST_OK; aout_in = '0; copy_in = '0; moving_in = 1'b0;
               state_in = S_DECODE;
            end
         end
         S_INIT: begin
            wr_en = 1'b1; wr_addr = '0;
            wr_data.offset = '0; wr_data.is_free = 1'b1;
            wr_data.size = (hb > HDR) ? hb - HDR : '0;
            count_in = CW'(1);
            state_in = S_IDLE;
         end
         S_DECODE: begin
            idx_in = '0;
            unique case (kind_ff)
               REQ_ALLOC: state_in = (rsize_ff == '0) ? S_SUM_RD : S_FIT_RD;
               REQ_RELEASE: begin
                  find_ret_in = RET_REL;
                  state_in = (addr_ff == '0) ? S_SUM_RD : S_FIND_RD;
               end
               REQ_RESIZE: begin
                  find_ret_in = RET_RSZ;
                  state_in = (addr_ff == '0) ? ((rsize_ff == '0) ? S_SUM_RD : S_FIT_RD)
                                             : S_FIND_RD;
               end
               default: begin
                  status_in = ST_NULL;
                  state_in = S_SUM_RD;
               end
            endcase
            if (rsize_ff == '0 && (kind_ff == REQ_ALLOC ||
                (kind_ff == REQ_RESIZE && addr_ff == '0))) status_in = ST_NULL;
         end
         S_FIND_RD: begin
            if (idx_ff >= count_ff) begin
               if (find_ret_ff == RET_MOVE) state_in = S_SUM_RD;
               else begin status_in = ST_UNKNOWN; state_in = S_SUM_RD; end
               idx_in = '0;
            end else state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (!rd_data.is_free && paddr == addr_ff) begin
               hit_in = idx_ff;
               if (find_ret_ff == RET_RSZ && rsize_ff != '0) begin
                  if (rd_data.size >= rsize_ff) begin
                     aout_in = addr_ff; state_in = S_SUM_RD; idx_in = '0;
                  end else begin
                     old_in = rd_data.size; moving_in = 1'b1; idx_in = '0;
                     state_in = S_FIT_RD;
                  end
               end else begin
                  if (find_ret_ff == RET_RSZ) status_in = ST_NULL;
                  state_in = S_FREE_MARK;
               end
            end else begin
               idx_in = idx_ff + CW'(1); state_in = S_FIND_RD;
            end
         end
         S_FIT_RD: begin
            if (idx_ff >= count_ff) begin
               status_in = ST_NULL; aout_in = '0; idx_in = '0; state_in = S_SUM_RD;
            end else state_in = S_FIT_CHK;
         end
         S_FIT_CHK: begin
            if (rd_data.is_free && {1'b0, rd_data.size} >= need_ff) begin
               hit_in = idx_ff;
               held_in = rd_data;
               aout_in = paddr;
               big = (SIZE_W+2)'(need_ff) + SPLIT_EXTRA;
               if ((SIZE_W+2)'(rd_data.size) >= big && count_ff < CW'(MAX_BLOCKS)) begin
                  idx_in = count_ff - CW'(1); state_in = S_SPLIT_RD;
               end else begin
                  wr_en = 1'b1; wr_data = rd_data; wr_data.is_free = 1'b0;
                  state_in = S_SPLIT_SET;
               end
            end else begin
               idx_in = idx_ff + CW'(1); state_in = S_FIT_RD;
            end
         end
         // shift entries hit+1..count-1 up by one, top first
         S_SPLIT_RD: begin
            if (idx_ff > hit_ff) state_in = S_SPLIT_WR;
            else begin
               wr_en = 1'b1; wr_addr = AW'(hit_ff + CW'(1));
               wr_data.offset = held_ff.offset + OFFS_W'(HEADER_BYTES) + need_ff[OFFS_W-1:0];
               wr_data.size = held_ff.size - need_ff[SIZE_W-1:0] - HDR;
               wr_data.is_free = 1'b1;
               held_in.size = need_ff[SIZE_W-1:0];
               count_in = count_ff + CW'(1);
               state_in = S_SPLIT_SET;
            end
         end
         S_SPLIT_WR: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff + CW'(1)); wr_data = rd_data;
            idx_in = idx_ff - CW'(1); state_in = S_SPLIT_RD;
         end
         S_SPLIT_SET: begin
            wr_en = 1'b1; wr_addr = hit_ff[AW-1:0];
            wr_data = held_ff; wr_data.is_free = 1'b0;
            idx_in = '0;
            if (moving_ff) begin
               copy_in = old_ff; find_ret_in = RET_MOVE; state_in = S_FIND_RD;
            end else state_in = S_SUM_RD;
         end
         S_FREE_MARK: begin
            wr_en = 1'b1; wr_addr = hit_ff[AW-1:0]; wr_data = rd_data;
            wr_data.is_free = 1'b1;
            idx_in = '0; state_in = S_MERGE_RD;
         end
         // held = entry i, read entry i+1
         S_MERGE_RD: begin
            if (idx_ff + CW'(1) >= count_ff) begin
               idx_in = '0; state_in = S_SUM_RD;
            end else state_in = S_MERGE_CHK;
         end
         S_MERGE_CHK: begin
            held_in = rd_data;
            rd_addr = AW'(idx_ff + CW'(1));
            state_in = S_DEL_RD;
         end
         S_DEL_RD: begin
            if (held_ff.is_free && rd_data.is_free) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
               wr_data = held_ff; wr_data.size = held_ff.size + HDR + rd_data.size;
               hit_in = idx_ff; idx_in = idx_ff + CW'(1);
               rd_addr = AW'(idx_ff + CW'(2));
               state_in = S_DEL_WR;
            end else begin
               idx_in = idx_ff + CW'(1); rd_addr = AW'(idx_ff + CW'(1));
               state_in = S_MERGE_RD;
            end
         end
         // remove entry idx by pulling later ones down
         S_DEL_WR: begin
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1); idx_in = hit_ff;
               rd_addr = hit_ff[AW-1:0]; state_in = S_MERGE_RD;
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
               idx_in = idx_ff + CW'(1); rd_addr = AW'(idx_ff + CW'(2));
            end
         end
         S_SUM_RD: begin
            if (idx_ff == '0) begin used_in = '0; free_in = '0; end
            if (idx_ff >= count_ff) state_in = S_RESP;
            else state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            if (rd_data.is_free) free_in = free_ff + rd_data.size;
            else used_in = used_ff + rd_data.size;
            idx_in = idx_ff + CW'(1); state_in = S_SUM_RD;
         end
         S_RESP: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in = 1'b1;
               out_status_in = status_ff; out_aout_in = aout_ff;
               out_copy_in = copy_ff; out_used_in = used_ff; out_free_in = free_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp.valid = rvalid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.address_out = out_aout_ff;
   assign rsp.copy_bytes = out_copy_ff;
   assign rsp.bytes_used = out_used_ff;
   assign rsp.bytes_free = out_free_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CW'(MAX_BLOCKS)) else $error("count out of range");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
   a_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !rvalid_ff) |=> rvalid_ff) else $error("response lost");
endmodule
`default_nettype wire
